FILE: src/rtp_fu_refragmenter_defines.svh
// assertion macros for the rtp fu refragmenter
// expect a clock named clk and an active-low reset named rst_n in scope
`ifndef RTP_FU_REFRAGMENTER_DEFINES_SVH
`define RTP_FU_REFRAGMENTER_DEFINES_SVH

// property checked every clock outside reset
`define RTPFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define RTPFR_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) else $error(msg);

`endif

FILE: src/rtpfr_pkg.sv
// shared widths, codes and interface types for the rtp fu refragmenter
// no dependencies
`timescale 1ns / 1ps

package rtpfr_pkg;

  localparam int LEN_W     = 13;
  localparam int HDR_W     = 6;
  localparam int PT_W      = 7;
  localparam int SEQ_W     = 16;
  localparam int START_W   = 12;
  localparam int PART_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_W     = 13;
  localparam int SLICE_W   = 14;
  localparam int K_W       = 5;

  localparam int MAX_RESULTS          = 32;
  localparam int MAX_PACKET_BYTES_DEF = 4096;

  localparam logic [LEN_W-1:0] BLOCK_FLOOR    = 13'd200;
  localparam logic [LEN_W-1:0] BLOCK_SIZE_RST = 13'd1400;
  localparam logic [PT_W-1:0]  H264_PT_RST    = 7'd96;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_H264_PT    = 2'd1;

  // fu part codes
  localparam logic [PART_W-1:0] FU_HEAD     = 2'd0;
  localparam logic [PART_W-1:0] FU_MID      = 2'd1;
  localparam logic [PART_W-1:0] FU_END      = 2'd2;
  localparam logic [PART_W-1:0] FU_RESERVED = 2'd3;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_stat_t;

endpackage

FILE: src/rtp_fu_refragmenter.sv
// top level: request decode, fragment sequencer and output register
// depends on rtpfr_pkg, rtpfr_divider and rtp_fu_refragmenter_defines.svh
`timescale 1ns / 1ps
`include "rtp_fu_refragmenter_defines.svh"

// Takes one packet descriptor per request and emits datagram descriptors.
// A packet that fits block_size goes out as one whole descriptor, through the
// check state and then the output register. An oversized H.264 FU packet is
// cut into N slices: a decode step, then two divisions (parts, then slice
// size) on a single shared restoring divider at one quotient bit per cycle,
// then one fragment per cycle while the output is not stalled, with N at most
// 32. Empty, too long or non-fragmentable packets are dropped in the check
// state and give nothing. in_stall is high from the cycle after a request is
// taken until its last fragment has been loaded into the output register or
// it is dropped. Every datagram takes the next sequence number; configuration
// writes are always taken (cfg_ready is high).
module rtp_fu_refragmenter #(
  parameter int MAX_PACKET_BYTES = rtpfr_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rtpfr_pkg::LEN_W-1:0]         in_packet_length,
  input  logic [rtpfr_pkg::HDR_W-1:0]         in_header_length,
  input  logic [rtpfr_pkg::LEN_W-1:0]         in_payload_length,
  input  logic [rtpfr_pkg::PT_W-1:0]          in_payload_type,
  input  logic                                in_is_fu_unit,
  input  logic [rtpfr_pkg::PART_W-1:0]        in_source_fu_part,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rtpfr_pkg::START_W-1:0]       out_slice_start,
  output logic [rtpfr_pkg::LEN_W-1:0]         out_slice_length,
  output logic [rtpfr_pkg::SEQ_W-1:0]         out_sequence_number,
  output logic [rtpfr_pkg::PART_W-1:0]        out_fu_part_out,
  output logic                                out_whole_packet,
  output logic                                out_last,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rtpfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtpfr_pkg::LEN_W-1:0]         cfg_data
);

  localparam int LW  = rtpfr_pkg::LEN_W;
  localparam int HW  = rtpfr_pkg::HDR_W;
  localparam int SW  = rtpfr_pkg::SLICE_W;
  localparam int KW  = rtpfr_pkg::K_W;
  localparam int STW = rtpfr_pkg::START_W;

  localparam logic [LW-1:0] MaxLen = LW'(MAX_PACKET_BYTES);
  localparam logic [KW-1:0] KLast  = KW'(rtpfr_pkg::MAX_RESULTS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV1  = 3'd2;
  localparam logic [2:0] S_DIV2  = 3'd3;
  localparam logic [2:0] S_FIRST = 3'd4;
  localparam logic [2:0] S_LOOP  = 3'd5;

  logic [2:0]                       state_r, state_nxt;
  logic [LW-1:0]                    bs_r;
  logic [rtpfr_pkg::PT_W-1:0]       pt_r;
  logic [rtpfr_pkg::SEQ_W-1:0]      seq_r, seq_nxt;

  logic [LW-1:0]                    plen_r, dlen_r;
  logic [HW-1:0]                    hlen_r;
  logic [rtpfr_pkg::PT_W-1:0]       ptype_r;
  logic                             fu_r;
  logic [rtpfr_pkg::PART_W-1:0]     src_r;
  logic [SW-1:0]                    slice_r, slice_nxt;
  logic [SW-1:0]                    off_r, off_nxt;
  logic [KW-1:0]                    k_r, k_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [STW-1:0]                   out_start_r;
  logic [LW-1:0]                    out_len_r;
  logic [rtpfr_pkg::SEQ_W-1:0]      out_seq_r;
  logic [rtpfr_pkg::PART_W-1:0]     out_part_r;
  logic                             out_whole_r, out_last_r;

  logic                             emit;
  logic [STW-1:0]                   e_start;
  logic [LW-1:0]                    e_len;
  logic [rtpfr_pkg::PART_W-1:0]     e_part;
  logic                             e_whole, e_last;

  rtpfr_pkg::div_ctrl_t             div_ctrl;
  rtpfr_pkg::div_stat_t             div_stat;

  logic                             in_take, slot_free;
  logic [LW-1:0]                    hdr13, hd_len, first_len, rem_len, loop_len;
  logic                             first_last, loop_final;
  logic [SW:0]                      end_sum;
  logic [SW-1:0]                    q_plus1;

  assign in_stall  = state_r != S_IDLE;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r <= rtpfr_pkg::BLOCK_SIZE_RST;
      pt_r <= rtpfr_pkg::H264_PT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rtpfr_pkg::REG_BLOCK_SIZE: begin
          bs_r <= (cfg_data < rtpfr_pkg::BLOCK_FLOOR) ? rtpfr_pkg::BLOCK_FLOOR : cfg_data;
        end
        rtpfr_pkg::REG_H264_PT: begin
          pt_r <= cfg_data[rtpfr_pkg::PT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign hdr13      = {{(LW-HW){1'b0}}, hlen_r};
  assign hd_len     = (plen_r > hdr13) ? (plen_r - hdr13) : '0;
  assign first_last = off_r >= {1'b0, plen_r};
  assign first_len  = ({1'b0, hd_len} > slice_r) ? slice_r[LW-1:0] : hd_len;
  assign rem_len    = plen_r - off_r[LW-1:0];
  assign end_sum    = {1'b0, off_r} + {1'b0, slice_r};
  assign loop_final = end_sum >= {2'b00, plen_r};
  assign loop_len   = ({1'b0, rem_len} > slice_r) ? slice_r[LW-1:0] : rem_len;
  assign q_plus1    = {1'b0, div_stat.quotient} + {{(SW-1){1'b0}}, 1'b1};

  always_comb begin
    state_nxt         = state_r;
    slice_nxt         = slice_r;
    off_nxt           = off_r;
    k_nxt             = k_r;
    emit              = 1'b0;
    e_start           = '0;
    e_len             = '0;
    e_part            = rtpfr_pkg::FU_HEAD;
    e_whole           = 1'b0;
    e_last            = 1'b0;
    div_ctrl.start    = 1'b0;
    div_ctrl.dividend = dlen_r;
    div_ctrl.divisor  = bs_r - hdr13;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (plen_r == '0 || plen_r > MaxLen) begin
          state_nxt = S_IDLE;
        end else if (plen_r <= bs_r) begin
          if (slot_free) begin
            emit      = 1'b1;
            e_start   = {{(STW-HW){1'b0}}, hlen_r};
            e_len     = hd_len;
            e_part    = fu_r ? src_r : rtpfr_pkg::FU_HEAD;
            e_whole   = 1'b1;
            e_last    = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (ptype_r != pt_r || !fu_r || hdr13 >= bs_r) begin
          state_nxt = S_IDLE;
        end else begin
          div_ctrl.start = 1'b1;
          state_nxt      = S_DIV1;
        end
      end
      S_DIV1: begin
        // parts = quotient + 1 becomes the divisor of the second pass
        div_ctrl.divisor = q_plus1[LW-1:0];
        if (div_stat.done) begin
          div_ctrl.start = 1'b1;
          state_nxt      = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_stat.done) begin
          slice_nxt = q_plus1;
          off_nxt   = q_plus1 + {{(SW-HW){1'b0}}, hlen_r};
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        if (slot_free) begin
          emit    = 1'b1;
          e_start = {{(STW-HW){1'b0}}, hlen_r};
          e_len   = first_len;
          e_last  = first_last;
          if (src_r == rtpfr_pkg::FU_HEAD) begin
            e_part = rtpfr_pkg::FU_HEAD;
          end else if (first_last && src_r == rtpfr_pkg::FU_END) begin
            e_part = rtpfr_pkg::FU_END;
          end else begin
            e_part = rtpfr_pkg::FU_MID;
          end
          k_nxt     = {{(KW-1){1'b0}}, 1'b1};
          state_nxt = first_last ? S_IDLE : S_LOOP;
        end
      end
      S_LOOP: begin
        if (slot_free) begin
          emit    = 1'b1;
          e_start = off_r[STW-1:0];
          e_len   = loop_len;
          e_part  = (loop_final && src_r == rtpfr_pkg::FU_END) ?
                    rtpfr_pkg::FU_END : rtpfr_pkg::FU_MID;
          // cap the fragment count, the last allowed one closes the packet
          e_last  = loop_final || k_r == KLast;
          off_nxt = off_r + {1'b0, loop_len};
          k_nxt   = k_r + 1'b1;
          if (e_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign seq_nxt       = emit ? (seq_r + 1'b1) : seq_r;
  assign out_valid_nxt = emit ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request capture and fragment bookkeeping
  always_ff @(posedge clk) begin
    if (in_take) begin
      plen_r  <= in_packet_length;
      hlen_r  <= in_header_length;
      dlen_r  <= in_payload_length;
      ptype_r <= in_payload_type;
      fu_r    <= in_is_fu_unit;
      src_r   <= (in_source_fu_part == rtpfr_pkg::FU_RESERVED) ?
                 rtpfr_pkg::FU_MID : in_source_fu_part;
    end
    slice_r <= slice_nxt;
    off_r   <= off_nxt;
    k_r     <= k_nxt;
    if (emit) begin
      out_start_r <= e_start;
      out_len_r   <= e_len;
      out_seq_r   <= seq_r + 1'b1;
      out_part_r  <= e_part;
      out_whole_r <= e_whole;
      out_last_r  <= e_last;
    end
  end

  rtpfr_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (div_ctrl),
    .stat  (div_stat)
  );

  assign out_valid           = out_valid_r;
  assign out_slice_start     = out_start_r;
  assign out_slice_length    = out_len_r;
  assign out_sequence_number = out_seq_r;
  assign out_fu_part_out     = out_part_r;
  assign out_whole_packet    = out_whole_r;
  assign out_last            = out_last_r;

  `RTPFR_ASSERT_NEXT(a_seq_step, emit, out_sequence_number == $past(seq_r) + 16'd1, "sequence skipped")
  `RTPFR_ASSERT(a_div_start_state, div_ctrl.start |-> (state_r == S_CHECK || state_r == S_DIV1), "stray divide")
  `RTPFR_ASSERT(a_loop_in_packet, (state_r == S_LOOP) |-> (!first_last && k_r != '0), "loop past packet end")
  `RTPFR_ASSERT(a_emit_slot, emit |-> slot_free, "fragment overwrote pending output")

endmodule

FILE: src/rtpfr_divider.sv
// serial restoring divider, one quotient bit per clock
// depends on rtpfr_pkg and rtp_fu_refragmenter_defines.svh
`timescale 1ns / 1ps
`include "rtp_fu_refragmenter_defines.svh"

module rtpfr_divider (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rtpfr_pkg::div_ctrl_t  ctrl,
  output rtpfr_pkg::div_stat_t  stat
);

  localparam int W   = rtpfr_pkg::DIV_W;
  localparam int CNT_W = $clog2(W);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [W:0]       rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     dvs_r, dvs_nxt;

  logic [W:0] trial;
  logic       fits;

  assign trial = {rem_r[W-1:0], quo_r[W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(W - 1);
      rem_nxt  = '0;
      quo_nxt  = ctrl.dividend;
      dvs_nxt  = ctrl.divisor;
    end else if (busy_r) begin
      // dividend bits shift out of the top while quotient bits enter below
      rem_nxt = fits ? (trial - {1'b0, dvs_r}) : trial;
      quo_nxt = {quo_r[W-2:0], fits};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy     = busy_r;
  assign stat.done     = done_r;
  assign stat.quotient = quo_r;

  `RTPFR_ASSERT(a_start_when_free, ctrl.start |-> !busy_r, "divider started while busy")
  `RTPFR_ASSERT_NEXT(a_done_pulse, done_r, !done_r, "done held for more than one cycle")
  `RTPFR_ASSERT(a_divisor_nonzero, busy_r |-> (dvs_r != '0), "division by zero in progress")

endmodule

FILE: tb/sv/rtp_fu_refragmenter_checker.sv
// datagram predictor and scoreboard for the rtp fu refragmenter
// watches the packet, datagram and register channels; depends on rtpfr_pkg
`timescale 1ns / 1ps

module rtp_fu_refragmenter_checker (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [rtpfr_pkg::LEN_W-1:0]         in_packet_length,
  input  logic [rtpfr_pkg::HDR_W-1:0]         in_header_length,
  input  logic [rtpfr_pkg::LEN_W-1:0]         in_payload_length,
  input  logic [rtpfr_pkg::PT_W-1:0]          in_payload_type,
  input  logic                                in_is_fu_unit,
  input  logic [rtpfr_pkg::PART_W-1:0]        in_source_fu_part,

  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [rtpfr_pkg::START_W-1:0]       out_slice_start,
  input  logic [rtpfr_pkg::LEN_W-1:0]         out_slice_length,
  input  logic [rtpfr_pkg::SEQ_W-1:0]         out_sequence_number,
  input  logic [rtpfr_pkg::PART_W-1:0]        out_fu_part_out,
  input  logic                                out_whole_packet,
  input  logic                                out_last,

  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [rtpfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtpfr_pkg::LEN_W-1:0]         cfg_data,

  output int                                  fail_count,
  output int                                  pending,
  output int                                  packets_taken,
  output int                                  datagrams_seen
);

  localparam int LW  = rtpfr_pkg::LEN_W;
  localparam int HW  = rtpfr_pkg::HDR_W;
  localparam int PTW = rtpfr_pkg::PT_W;
  localparam int PRW = rtpfr_pkg::PART_W;
  localparam int STW = rtpfr_pkg::START_W;
  localparam int SQW = rtpfr_pkg::SEQ_W;

  typedef struct packed {
    logic [STW-1:0] start;
    logic [LW-1:0]  len;
    logic [SQW-1:0] seq;
    logic [PRW-1:0] part;
    logic           whole;
    logic           last;
  } datagram_t;

  datagram_t          datagram_q[$];
  datagram_t          want;
  logic [LW-1:0]      block_size_r;
  logic [PTW-1:0]     h264_pt_r;
  logic [SQW-1:0]     seq_r;

  initial begin
    fail_count     = 0;
    pending        = 0;
    packets_taken  = 0;
    datagrams_seen = 0;
  end

  // every datagram takes the next sequence number
  task automatic emit(input int unsigned start, input int unsigned len,
                      input logic [PRW-1:0] part, input logic whole,
                      input logic last);
    datagram_t d;
    seq_r   = seq_r + 1'b1;
    d.start = start[STW-1:0];
    d.len   = len[LW-1:0];
    d.seq   = seq_r;
    d.part  = part;
    d.whole = whole;
    d.last  = last;
    datagram_q.push_back(d);
  endtask

  task automatic predict_datagrams(input logic [LW-1:0] plen,
                                   input logic [HW-1:0] hlen,
                                   input logic [LW-1:0] dlen,
                                   input logic [PTW-1:0] ptype,
                                   input logic fu,
                                   input logic [PRW-1:0] src_part);
    int unsigned       p, h, d, bs, parts, slice, len, off, k;
    logic [PRW-1:0]    src, part;
    bit                fin;
    p  = plen;
    h  = hlen;
    d  = dlen;
    bs = block_size_r;
    src = (src_part == rtpfr_pkg::FU_RESERVED) ? rtpfr_pkg::FU_MID : src_part;
    if (p == 0 || p > rtpfr_pkg::MAX_PACKET_BYTES_DEF) return;

    if (p <= bs) begin
      len = (p > h) ? p - h : 0;
      emit(h, len, fu ? src : rtpfr_pkg::FU_HEAD, 1'b1, 1'b1);
      return;
    end

    if (ptype != h264_pt_r || !fu || h >= bs) return;

    parts = d / (bs - h) + 1;
    slice = d / parts + 1;

    off = slice + h;
    len = (p > h) ? p - h : 0;
    if (len > slice) len = slice;
    if (src == rtpfr_pkg::FU_HEAD)
      part = rtpfr_pkg::FU_HEAD;
    else if (off >= p && src == rtpfr_pkg::FU_END)
      part = rtpfr_pkg::FU_END;
    else
      part = rtpfr_pkg::FU_MID;
    emit(h, len, part, 1'b0, off >= p);

    // remaining slices, capped at the result limit
    k = 1;
    while (off < p && k < rtpfr_pkg::MAX_RESULTS) begin
      fin  = (off + slice >= p);
      part = (fin && src == rtpfr_pkg::FU_END) ? rtpfr_pkg::FU_END : rtpfr_pkg::FU_MID;
      len  = p - off;
      if (len > slice) len = slice;
      emit(off, len, part, 1'b0, fin || k == rtpfr_pkg::MAX_RESULTS - 1);
      off += len;
      k++;
    end
  endtask

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      block_size_r = rtpfr_pkg::BLOCK_SIZE_RST;
      h264_pt_r    = rtpfr_pkg::H264_PT_RST;
      seq_r        = '0;
      datagram_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        datagrams_seen++;
        if (datagram_q.size() == 0) begin
          $display("%0t: unexpected datagram, expected none, actual seq %0d start %0d len %0d",
                   $time, out_sequence_number, out_slice_start, out_slice_length);
          fail_count++;
        end else begin
          want = datagram_q.pop_front();
          compare_field("slice_start", want.start, out_slice_start);
          compare_field("slice_length", want.len, out_slice_length);
          compare_field("sequence_number", want.seq, out_sequence_number);
          compare_field("fu_part_out", want.part, out_fu_part_out);
          compare_field("whole_packet", want.whole, out_whole_packet);
          compare_field("last", want.last, out_last);
        end
      end

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rtpfr_pkg::REG_BLOCK_SIZE)
          block_size_r = (cfg_data < rtpfr_pkg::BLOCK_FLOOR) ?
                         rtpfr_pkg::BLOCK_FLOOR : cfg_data;
        else if (cfg_index == rtpfr_pkg::REG_H264_PT)
          h264_pt_r = cfg_data[PTW-1:0];
      end

      if (in_valid && !in_stall) begin
        packets_taken++;
        predict_datagrams(in_packet_length, in_header_length, in_payload_length,
                          in_payload_type, in_is_fu_unit, in_source_fu_part);
      end
    end
    pending = datagram_q.size();
  end

endmodule

FILE: tb/sv/tb_rtp_fu_refragmenter.sv
// testbench top for the rtp fu refragmenter: clock, reset, packet requests,
// register writes and receiver stalls; depends on rtpfr_pkg and the checker
`timescale 1ns / 1ps

module tb_rtp_fu_refragmenter;

  localparam int LW  = rtpfr_pkg::LEN_W;
  localparam int HW  = rtpfr_pkg::HDR_W;
  localparam int PTW = rtpfr_pkg::PT_W;
  localparam int PRW = rtpfr_pkg::PART_W;
  localparam int CIW = rtpfr_pkg::CFG_IDX_W;
  localparam int MAXB = rtpfr_pkg::MAX_PACKET_BYTES_DEF;

  typedef struct {
    logic [LW-1:0]  plen;
    logic [HW-1:0]  hlen;
    logic [LW-1:0]  dlen;
    logic [PTW-1:0] ptype;
    logic           fu;
    logic [PRW-1:0] part;
  } packet_t;

  localparam int LEN_MAX       = (1 << LW) - 1;
  localparam int HDR_MAX       = (1 << HW) - 1;
  localparam int PT_MAX        = (1 << PTW) - 1;
  localparam int SETTLE_CYCLES = 100;
  localparam int TAIL_CYCLES   = 200;
  localparam int HOLD_CYCLES   = 400;

  // indexes that map to no register
  localparam logic [CIW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CIW-1:0] REG_SPARE_B = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [LW-1:0]        in_packet_length = '0;
  logic [HW-1:0]        in_header_length = '0;
  logic [LW-1:0]        in_payload_length = '0;
  logic [PTW-1:0]       in_payload_type = '0;
  logic                 in_is_fu_unit = 1'b0;
  logic [PRW-1:0]       in_source_fu_part = rtpfr_pkg::FU_HEAD;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [rtpfr_pkg::START_W-1:0] out_slice_start;
  logic [LW-1:0]        out_slice_length;
  logic [rtpfr_pkg::SEQ_W-1:0] out_sequence_number;
  logic [PRW-1:0]       out_fu_part_out;
  logic                 out_whole_packet;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CIW-1:0]       cfg_index = rtpfr_pkg::REG_BLOCK_SIZE;
  logic [LW-1:0]        cfg_data = '0;

  int                   fail_count, pending, packets_taken, datagrams_seen;
  int                   send_idle_pct = 0;
  int                   stall_pct = 0;
  logic                 hold_req = 1'b0;
  int                   hold_left = 0;
  bit                   hold_done = 1'b0;
  logic [LW-1:0]        cur_bs = rtpfr_pkg::BLOCK_SIZE_RST;
  logic [PTW-1:0]       cur_pt = rtpfr_pkg::H264_PT_RST;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rtp_fu_refragmenter u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_packet_length    (in_packet_length),
    .in_header_length    (in_header_length),
    .in_payload_length   (in_payload_length),
    .in_payload_type     (in_payload_type),
    .in_is_fu_unit       (in_is_fu_unit),
    .in_source_fu_part   (in_source_fu_part),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_slice_start     (out_slice_start),
    .out_slice_length    (out_slice_length),
    .out_sequence_number (out_sequence_number),
    .out_fu_part_out     (out_fu_part_out),
    .out_whole_packet    (out_whole_packet),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  rtp_fu_refragmenter_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_packet_length    (in_packet_length),
    .in_header_length    (in_header_length),
    .in_payload_length   (in_payload_length),
    .in_payload_type     (in_payload_type),
    .in_is_fu_unit       (in_is_fu_unit),
    .in_source_fu_part   (in_source_fu_part),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_slice_start     (out_slice_start),
    .out_slice_length    (out_slice_length),
    .out_sequence_number (out_sequence_number),
    .out_fu_part_out     (out_fu_part_out),
    .out_whole_packet    (out_whole_packet),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .pending             (pending),
    .packets_taken       (packets_taken),
    .datagrams_seen      (datagrams_seen)
  );

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  function automatic packet_t mk_packet(input int plen, input int hlen, input int dlen,
                                        input int ptype, input logic fu,
                                        input logic [PRW-1:0] part);
    packet_t p;
    p.plen  = LW'(plen);
    p.hlen  = HW'(hlen);
    p.dlen  = LW'(dlen);
    p.ptype = PTW'(ptype);
    p.fu    = fu;
    p.part  = part;
    return p;
  endfunction

  // mostly well-formed oversized fu packets, then whole packets, then noise
  function automatic packet_t random_packet();
    packet_t p;
    int      r;
    int      hi;
    r       = $urandom_range(99, 0);
    hi      = (cur_bs < MAXB) ? int'(cur_bs) : MAXB;
    p.part  = PRW'($urandom_range(3, 0));
    p.fu    = 1'b1;
    p.ptype = cur_pt;
    p.hlen  = HW'($urandom_range(HDR_MAX, 0));
    p.dlen  = LW'($urandom_range(LEN_MAX, 0));
    if (r < 60 && cur_bs < MAXB) begin
      p.plen = LW'($urandom_range(MAXB, int'(cur_bs) + 1));
      if (r < 45) p.dlen = p.plen - {{(LW-HW){1'b0}}, p.hlen};
    end else if (r < 85) begin
      p.plen  = LW'($urandom_range(hi, 1));
      if (p.plen > {{(LW-HW){1'b0}}, p.hlen}) p.dlen = p.plen - {{(LW-HW){1'b0}}, p.hlen};
      p.ptype = PTW'($urandom_range(PT_MAX, 0));
      p.fu    = 1'($urandom_range(1, 0));
    end else begin
      case ($urandom_range(3, 0))
        0: p.plen = '0;
        1: p.plen = LW'($urandom_range(LEN_MAX, MAXB + 1));
        2: begin
          p.plen  = LW'($urandom_range(MAXB, 1));
          p.ptype = cur_pt ^ PTW'(7'd1 << $urandom_range(PTW - 1, 0));
        end
        default: begin
          p.plen = LW'($urandom_range(MAXB, 1));
          p.fu   = 1'b0;
        end
      endcase
    end
    return p;
  endfunction

  task automatic send_packet(input packet_t p);
    int gap;
    gap = 0;
    while ($urandom_range(99, 0) < send_idle_pct && gap < 50) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_packet_length  <= p.plen;
    in_header_length  <= p.hlen;
    in_payload_length <= p.dlen;
    in_payload_type   <= p.ptype;
    in_is_fu_unit     <= p.fu;
    in_source_fu_part <= p.part;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIW-1:0] idx, input int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= LW'(data);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == rtpfr_pkg::REG_BLOCK_SIZE)
      cur_bs = (LW'(data) < rtpfr_pkg::BLOCK_FLOOR) ? rtpfr_pkg::BLOCK_FLOOR : LW'(data);
    else if (idx == rtpfr_pkg::REG_H264_PT)
      cur_pt = PTW'(data);
    @(posedge clk);
  endtask

  // drain all expected datagrams, then give dropped packets time to retire
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int count, input int hold_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req <= 1'b1;
      send_packet(random_packet());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // sender mostly busy, receiver mostly stalled
    send_idle_pct = 6;
    stall_pct     = 68;

    // directed packets at reset settings (block 1400, type 96)
    send_packet(mk_packet(0, 0, 0, 96, 1'b1, rtpfr_pkg::FU_HEAD));          // empty
    send_packet(mk_packet(4097, 12, 4085, 96, 1'b1, rtpfr_pkg::FU_HEAD));   // too long
    send_packet(mk_packet(LEN_MAX, HDR_MAX, LEN_MAX, PT_MAX, 1'b1, rtpfr_pkg::FU_RESERVED));
    send_packet(mk_packet(1, 0, 1, 0, 1'b1, rtpfr_pkg::FU_HEAD));           // smallest whole
    send_packet(mk_packet(1400, 12, 1388, 96, 1'b1, rtpfr_pkg::FU_END));    // exactly block size
    send_packet(mk_packet(10, HDR_MAX, 0, 96, 1'b0, rtpfr_pkg::FU_END));    // header past packet
    send_packet(mk_packet(700, 20, 680, 5, 1'b1, rtpfr_pkg::FU_RESERVED));  // whole, part three
    send_packet(mk_packet(3000, 14, 2986, 96, 1'b1, rtpfr_pkg::FU_HEAD));
    send_packet(mk_packet(1401, 14, 1387, 96, 1'b1, rtpfr_pkg::FU_MID));    // just oversized
    send_packet(mk_packet(4096, HDR_MAX, 4033, 96, 1'b1, rtpfr_pkg::FU_END));
    send_packet(mk_packet(2500, 12, 2488, 96, 1'b1, rtpfr_pkg::FU_RESERVED));
    send_packet(mk_packet(2000, 12, 1988, 97, 1'b1, rtpfr_pkg::FU_HEAD));   // wrong type
    send_packet(mk_packet(2000, 12, 1988, 96, 1'b0, rtpfr_pkg::FU_HEAD));   // not fu
    send_packet(mk_packet(4096, 0, 100, 96, 1'b1, rtpfr_pkg::FU_END));      // hits slice cap
    send_packet(mk_packet(2000, 40, 0, 96, 1'b1, rtpfr_pkg::FU_HEAD));      // one-byte slices
    send_packet(mk_packet(4096, 0, LEN_MAX, 96, 1'b1, rtpfr_pkg::FU_MID));
    send_packet(mk_packet(1800, 12, 900, 96, 1'b1, rtpfr_pkg::FU_END));     // short payload
    send_packet(mk_packet(4095, 33, 4062, 96, 1'b1, rtpfr_pkg::FU_HEAD));

    // smallest block (floored), type zero, unused indexes
    settle();
    write_reg(rtpfr_pkg::REG_BLOCK_SIZE, 0);
    write_reg(rtpfr_pkg::REG_H264_PT, 0);
    write_reg(REG_SPARE_A, LEN_MAX);
    write_reg(REG_SPARE_B, 0);
    run_random(130, -1);

    // swap idling: sender mostly idle, receiver mostly ready
    settle();
    send_idle_pct = 68;
    stall_pct     = 6;
    write_reg(rtpfr_pkg::REG_BLOCK_SIZE, MAXB);
    write_reg(rtpfr_pkg::REG_H264_PT, PT_MAX);
    run_random(40, -1);
    settle();
    write_reg(rtpfr_pkg::REG_BLOCK_SIZE, $urandom_range(1200, 201));
    write_reg(rtpfr_pkg::REG_H264_PT, $urandom_range(PT_MAX, 0));
    run_random(90, -1);

    // no random idling from here on, only the one long receiver hold-off
    settle();
    send_idle_pct = 0;
    stall_pct     = 0;
    write_reg(rtpfr_pkg::REG_BLOCK_SIZE, LEN_MAX);
    write_reg(rtpfr_pkg::REG_H264_PT, int'(rtpfr_pkg::H264_PT_RST));
    run_random(20, -1);
    settle();
    write_reg(rtpfr_pkg::REG_BLOCK_SIZE, $urandom_range(2000, 300));
    write_reg(rtpfr_pkg::REG_H264_PT, $urandom_range(PT_MAX, 0));
    run_random(130, 40);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d packet requests and %0d datagrams over six register settings,",
             packets_taken, datagrams_seen);
    $display("with random stalls on both sides and one long receiver hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d datagrams still expected", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: rtp_fu_refragmenter.f
+incdir+src
src/rtpfr_pkg.sv
src/rtpfr_divider.sv
src/rtp_fu_refragmenter.sv
tb/sv/rtp_fu_refragmenter_checker.sv
tb/sv/tb_rtp_fu_refragmenter.sv
